>>> sv/assert_macros.svh
// Assertion macros used by the flash command model RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define PNFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define PNFC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> sv/pnfc_pkg.sv
// Types, constants and command codes of the parallel NOR flash command model.
`default_nettype none

package pnfc_pkg;

  localparam int ADDR_BITS_DEF   = 16;
  localparam int SECTOR_BITS_DEF = 12;
  localparam int TICK_W          = 24;
  localparam int BYTE_W          = 8;
  localparam int CMD_ADDR_W      = 15;
  localparam int IN_ADDR_W       = 16;
  localparam int CFG_IDX_W       = 2;

  localparam logic [CMD_ADDR_W-1:0] UNLOCK1_ADDR = 15'h5555;
  localparam logic [CMD_ADDR_W-1:0] UNLOCK2_ADDR = 15'h2AAA;

  localparam logic [BYTE_W-1:0] CMD_AA = 8'hAA;
  localparam logic [BYTE_W-1:0] CMD_55 = 8'h55;
  localparam logic [BYTE_W-1:0] CMD_90 = 8'h90;
  localparam logic [BYTE_W-1:0] CMD_F0 = 8'hF0;
  localparam logic [BYTE_W-1:0] CMD_80 = 8'h80;
  localparam logic [BYTE_W-1:0] CMD_30 = 8'h30;
  localparam logic [BYTE_W-1:0] CMD_A0 = 8'hA0;

  localparam logic [BYTE_W-1:0] TOGGLE_BASE = 8'hBF;
  localparam logic [BYTE_W-1:0] TOGGLE_BIT  = 8'h40;
  localparam logic [BYTE_W-1:0] ERASED_BYTE = 8'hFF;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    DC_OTHER,
    DC_AA,
    DC_55,
    DC_90,
    DC_A0,
    DC_80,
    DC_30,
    DC_F0
  } data_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ERASE_TICKS   = 2'd0,
    CFG_PROGRAM_TICKS = 2'd1,
    CFG_MANUF_CODE    = 2'd2,
    CFG_DEVICE_CODE   = 2'd3
  } cfg_idx_e;

  // Classified bus word as it travels from front to back.
  typedef struct packed {
    kind_e              kind;
    logic               at_unlock1;
    logic               at_unlock2;
    data_e              dcode;
    logic [BYTE_W-1:0]  data;
  } item_t;

  typedef struct packed {
    logic [TICK_W-1:0] erase_ticks;
    logic [TICK_W-1:0] program_ticks;
    logic [BYTE_W-1:0] manuf_code;
    logic [BYTE_W-1:0] device_code;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    erase_ticks:   24'd1000,
    program_ticks: 24'd20,
    manuf_code:    8'hBF,
    device_code:   8'hB7
  };

endpackage

`default_nettype wire

>>> sv/pnfc_ram.sv
// Generic single write port, single read port RAM with registered read.
`default_nettype none

module pnfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> sv/pnfc_queue.sv
// Two-entry queue between the front and the back.
`default_nettype none

module pnfc_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] rdata_o,
  output logic                  empty_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic             wptr_q, wptr_d;
  logic             rptr_q, rptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = slot_q[rptr_q];

  always_comb begin
    wptr_d = do_push ? !wptr_q : wptr_q;
    rptr_d = do_pop ? !rptr_q : rptr_q;
    cnt_d  = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

>>> sv/pnfc_front.sv
// Front end: takes bus words, decodes command addresses and data codes.
`default_nettype none

module pnfc_front import pnfc_pkg::*; #(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [1:0]            kind_i,
  input  wire logic [IN_ADDR_W-1:0]  address_i,
  input  wire logic [BYTE_W-1:0]     write_data_i,
  input  wire logic                  q_full_i,
  input  wire logic                  clearing_i,
  output logic                       q_push_o,
  output item_t                      item_o,
  output logic      [ADDR_BITS-1:0]  addr_o
);

  data_e dcode;

  // Hold off new words while the array is wiped after reset.
  assign full     = q_full_i || clearing_i;
  assign q_push_o = push && !full;

  always_comb begin
    unique case (write_data_i)
      CMD_AA:  dcode = DC_AA;
      CMD_55:  dcode = DC_55;
      CMD_90:  dcode = DC_90;
      CMD_A0:  dcode = DC_A0;
      CMD_80:  dcode = DC_80;
      CMD_30:  dcode = DC_30;
      CMD_F0:  dcode = DC_F0;
      default: dcode = DC_OTHER;
    endcase
  end

  always_comb begin
    item_o.kind       = kind_e'(kind_i);
    item_o.at_unlock1 = (address_i[CMD_ADDR_W-1:0] == UNLOCK1_ADDR);
    item_o.at_unlock2 = (address_i[CMD_ADDR_W-1:0] == UNLOCK2_ADDR);
    item_o.dcode      = dcode;
    item_o.data       = write_data_i;
  end

  assign addr_o = ADDR_BITS'(address_i);

endmodule

`default_nettype wire

>>> sv/pnfc_back.sv
// Back end: command sequencer, busy timer, array access and result register.
`default_nettype none

`include "assert_macros.svh"

module pnfc_back import pnfc_pkg::*; #(
  parameter int ADDR_BITS   = ADDR_BITS_DEF,
  parameter int SECTOR_BITS = SECTOR_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  cfg_t                       cfg_i,
  input  wire logic                  q_empty_i,
  input  item_t                      item_i,
  input  wire logic [ADDR_BITS-1:0]  addr_i,
  output logic                       q_pop_o,
  output logic                       clearing_o,
  output logic                       ram_we_o,
  output logic      [ADDR_BITS-1:0]  ram_waddr_o,
  output logic      [BYTE_W-1:0]     ram_wdata_o,
  output logic                       ram_re_o,
  output logic      [ADDR_BITS-1:0]  ram_raddr_o,
  input  wire logic [BYTE_W-1:0]     ram_rdata_i,
  output logic                       empty,
  input  wire logic                  pop,
  output logic      [BYTE_W-1:0]     read_data_o,
  output logic                       busy_res_o
);

  localparam int AW = ADDR_BITS;
  localparam int SB = (SECTOR_BITS > ADDR_BITS) ? ADDR_BITS : SECTOR_BITS;
  localparam logic [AW-1:0] SecMask = {AW{1'b1}} >> (AW - SB);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_WAIT,
    S_PRG_WAIT,
    S_ERASE
  } state_e;

  typedef enum logic [2:0] {
    STEP_IDLE     = 3'd0,
    STEP_UNLOCK1  = 3'd1,
    STEP_UNLOCK2  = 3'd2,
    STEP_PROGRAM  = 3'd3,
    STEP_ERASE0   = 3'd4,
    STEP_ERASE1   = 3'd5,
    STEP_ERASE2   = 3'd6
  } step_e;

  state_e             st_q, st_d;
  step_e              step_q, step_d;
  logic               id_q, id_d;
  logic [TICK_W-1:0]  busy_q, busy_d;
  logic               tog_q, tog_d;
  logic [AW-1:0]      cnt_q, cnt_d;
  logic [AW-1:0]      base_q, base_d;
  logic [AW-1:0]      mask_q, mask_d;
  logic [AW-1:0]      paddr_q, paddr_d;
  logic [BYTE_W-1:0]  pdata_q, pdata_d;
  logic               ov_q, ov_d;
  logic [BYTE_W-1:0]  rd_q, rd_d;
  logic               br_q, br_d;
  logic               slot_free;
  logic               res_push;
  logic [BYTE_W-1:0]  res_rd;
  logic               sweeping;
  logic               wr_busy;
  logic               tick_busy;

  assign slot_free  = !ov_q || pop;
  assign clearing_o = (st_q == S_CLEAR);
  assign empty       = !ov_q;
  assign read_data_o = rd_q;
  assign busy_res_o  = br_q;

  always_comb begin
    st_d        = st_q;
    step_d      = step_q;
    id_d        = id_q;
    busy_d      = busy_q;
    tog_d       = tog_q;
    cnt_d       = cnt_q;
    base_d      = base_q;
    mask_d      = mask_q;
    paddr_d     = paddr_q;
    pdata_d     = pdata_q;
    q_pop_o     = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = base_q | (cnt_q & mask_q);
    ram_wdata_o = ERASED_BYTE;
    ram_re_o    = 1'b0;
    ram_raddr_o = addr_i;
    res_push    = 1'b0;
    res_rd      = '0;

    unique case (st_q)
      S_CLEAR, S_ERASE: begin
        // Sweep the range with erased bytes, one per cycle.
        ram_we_o = 1'b1;
        cnt_d    = cnt_q + AW'(1);
        if ((cnt_q & mask_q) == mask_q) begin
          cnt_d = '0;
          st_d  = S_IDLE;
        end
      end
      S_PRG_WAIT: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = paddr_q;
        ram_wdata_o = ram_rdata_i & pdata_q;
        st_d        = S_IDLE;
      end
      S_RD_WAIT: begin
        if (slot_free) begin
          res_push = 1'b1;
          res_rd   = ram_rdata_i;
          st_d     = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!q_empty_i && slot_free) begin
          q_pop_o = 1'b1;
          unique case (item_i.kind)
            KIND_READ: begin
              if (busy_q != '0) begin
                res_push = 1'b1;
                res_rd   = TOGGLE_BASE | (tog_q ? TOGGLE_BIT : '0);
                tog_d    = !tog_q;
              end else if (id_q) begin
                res_push = 1'b1;
                res_rd   = addr_i[0] ? cfg_i.device_code : cfg_i.manuf_code;
              end else begin
                ram_re_o = 1'b1;
                st_d     = S_RD_WAIT;
              end
            end
            KIND_WRITE: begin
              res_push = 1'b1;
              if (busy_q == '0) begin
                step_d = STEP_IDLE;
                priority if (step_q == STEP_PROGRAM) begin
                  // Fetch the old byte, AND the new one in next cycle.
                  ram_re_o = 1'b1;
                  paddr_d  = addr_i;
                  pdata_d  = item_i.data;
                  busy_d   = cfg_i.program_ticks;
                  st_d     = S_PRG_WAIT;
                end else if (item_i.dcode == DC_F0) begin
                  id_d = 1'b0;
                end else begin
                  unique case (step_q)
                    STEP_UNLOCK1: begin
                      if (item_i.at_unlock2 && item_i.dcode == DC_55) begin
                        step_d = STEP_UNLOCK2;
                      end
                    end
                    STEP_UNLOCK2: begin
                      if (item_i.at_unlock1) begin
                        priority if (item_i.dcode == DC_90) begin
                          id_d = 1'b1;
                        end else if (item_i.dcode == DC_A0) begin
                          step_d = STEP_PROGRAM;
                        end else if (item_i.dcode == DC_80) begin
                          step_d = STEP_ERASE0;
                        end else begin
                          step_d = STEP_IDLE;
                        end
                      end
                    end
                    STEP_ERASE0: begin
                      if (item_i.at_unlock1 && item_i.dcode == DC_AA) begin
                        step_d = STEP_ERASE1;
                      end
                    end
                    STEP_ERASE1: begin
                      if (item_i.at_unlock2 && item_i.dcode == DC_55) begin
                        step_d = STEP_ERASE2;
                      end
                    end
                    STEP_ERASE2: begin
                      if (item_i.dcode == DC_30) begin
                        busy_d = cfg_i.erase_ticks;
                        base_d = addr_i & ~SecMask;
                        mask_d = SecMask;
                        cnt_d  = '0;
                        st_d   = S_ERASE;
                      end
                    end
                    default: begin
                      if (item_i.at_unlock1 && item_i.dcode == DC_AA) begin
                        step_d = STEP_UNLOCK1;
                      end
                    end
                  endcase
                end
              end
            end
            KIND_TICK: begin
              res_push = 1'b1;
              if (busy_q != '0) begin
                busy_d = busy_q - TICK_W'(1);
              end
            end
            default: begin
              res_push = 1'b1;
            end
          endcase
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase

    ov_d = ov_q && !pop;
    rd_d = rd_q;
    br_d = br_q;
    if (res_push) begin
      ov_d = 1'b1;
      rd_d = res_rd;
      br_d = (busy_d != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_CLEAR;
      step_q  <= STEP_IDLE;
      id_q    <= 1'b0;
      busy_q  <= '0;
      tog_q   <= 1'b0;
      cnt_q   <= '0;
      base_q  <= '0;
      mask_q  <= '1;
      paddr_q <= '0;
      pdata_q <= '0;
      ov_q    <= 1'b0;
      rd_q    <= '0;
      br_q    <= 1'b0;
    end else begin
      st_q    <= st_d;
      step_q  <= step_d;
      id_q    <= id_d;
      busy_q  <= busy_d;
      tog_q   <= tog_d;
      cnt_q   <= cnt_d;
      base_q  <= base_d;
      mask_q  <= mask_d;
      paddr_q <= paddr_d;
      pdata_q <= pdata_d;
      ov_q    <= ov_d;
      rd_q    <= rd_d;
      br_q    <= br_d;
    end
  end

  assign sweeping  = (st_q == S_CLEAR) || (st_q == S_ERASE);
  assign wr_busy   = q_pop_o && (item_i.kind == KIND_WRITE) && (busy_q != '0);
  assign tick_busy = q_pop_o && (item_i.kind == KIND_TICK) && (busy_q != '0);

  `PNFC_ASSERT(a_no_pop_in_sweep, sweeping |-> !q_pop_o, "word taken during sweep")
  `PNFC_ASSERT(a_busy_write_ignored,
    wr_busy |=> (step_q == $past(step_q) && id_q == $past(id_q)),
    "write while busy changed state")
  `PNFC_ASSERT(a_tick_decrements,
    tick_busy |=> (busy_q == $past(busy_q) - TICK_W'(1)),
    "tick did not lower busy count")
  `PNFC_ASSERT_ALWAYS(a_no_result_overwrite, res_push |-> slot_free, "result overwrote a word")

endmodule

`default_nettype wire

>>> sv/parallel_nor_flash_command_model_unit.sv
// Parallel NOR flash command model: top level with configuration registers.
//
// Input words (kind_i, address_i, write_data_i) are pushed with push and are
// taken at an edge with push high and full low. Results (read_data_o,
// busy_res_o) appear while empty is low and are taken at an edge with pop
// high. Every input word yields exactly one result word, in order.
// Configuration is a plain write port: cfg_we_i, cfg_idx_i, cfg_wdata_i.
// Results are registered in the back end, which finishes one word per
// cycle while its result slot is free or popped; an array read or a
// byte program holds it in S_RD_WAIT or S_PRG_WAIT (registered read of
// the array RAM), and a sector erase in S_ERASE while it writes FF one
// byte per cycle over 2**min(SECTOR_BITS, ADDR_BITS) bytes. A two-word
// queue sits between front and back. After reset the array is wiped to
// FF; full stays high throughout. When pop stays low one result waits
// and the back stops; the queue then fills and full rises.
`default_nettype none

module parallel_nor_flash_command_model_unit import pnfc_pkg::*; #(
  parameter int ADDR_BITS   = ADDR_BITS_DEF,
  parameter int SECTOR_BITS = SECTOR_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [TICK_W-1:0]     cfg_wdata_i,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [1:0]            kind_i,
  input  wire logic [IN_ADDR_W-1:0]  address_i,
  input  wire logic [BYTE_W-1:0]     write_data_i,
  output logic                       empty,
  input  wire logic                  pop,
  output logic      [BYTE_W-1:0]     read_data_o,
  output logic                       busy_res_o
);

  localparam int QW = ADDR_BITS + $bits(item_t);

  cfg_t                  cfg_q;
  logic                  q_full, q_empty, q_push, q_pop, clearing;
  item_t                 f_item, b_item;
  logic [ADDR_BITS-1:0]  f_addr, b_addr;
  logic [QW-1:0]         q_rdata;
  logic                  ram_we, ram_re;
  logic [ADDR_BITS-1:0]  ram_waddr, ram_raddr;
  logic [BYTE_W-1:0]     ram_wdata, ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ERASE_TICKS:   cfg_q.erase_ticks   <= cfg_wdata_i;
        CFG_PROGRAM_TICKS: cfg_q.program_ticks <= cfg_wdata_i;
        CFG_MANUF_CODE:    cfg_q.manuf_code    <= cfg_wdata_i[BYTE_W-1:0];
        CFG_DEVICE_CODE:   cfg_q.device_code   <= cfg_wdata_i[BYTE_W-1:0];
        default:           cfg_q               <= cfg_q;
      endcase
    end
  end

  pnfc_front #(
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .push         (push),
    .full         (full),
    .kind_i       (kind_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .q_full_i     (q_full),
    .clearing_i   (clearing),
    .q_push_o     (q_push),
    .item_o       (f_item),
    .addr_o       (f_addr)
  );

  pnfc_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i ({f_addr, f_item}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  assign b_addr = q_rdata[QW-1 -: ADDR_BITS];
  assign b_item = item_t'(q_rdata[$bits(item_t)-1:0]);

  pnfc_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (1 << ADDR_BITS)
  ) u_array (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  pnfc_back #(
    .ADDR_BITS   (ADDR_BITS),
    .SECTOR_BITS (SECTOR_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_empty_i   (q_empty),
    .item_i      (b_item),
    .addr_i      (b_addr),
    .q_pop_o     (q_pop),
    .clearing_o  (clearing),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .empty       (empty),
    .pop         (pop),
    .read_data_o (read_data_o),
    .busy_res_o  (busy_res_o)
  );

endmodule

`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for the parallel NOR flash command model unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pnfc_pkg::*;

  localparam int MEM_SIZE     = 1 << ADDR_BITS_DEF;
  localparam int SEC_BYTES    =
    1 << ((SECTOR_BITS_DEF < ADDR_BITS_DEF) ? SECTOR_BITS_DEF : ADDR_BITS_DEF);
  localparam int DRAIN_CYCLES = SEC_BYTES + 64;
  localparam int STUCK_LIMIT  = 300000;
  localparam int MAX_REPORTS  = 10;
  localparam int TICK_CLIP    = 12;
  localparam int PHASE_WORDS  = 200;
  localparam int TAIL_WORDS   = 150;
  localparam logic [TICK_W-1:0] TICKS_MAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UNLOCK1,
    ST_UNLOCK2,
    ST_PROGRAM,
    ST_ERASE_AA,
    ST_ERASE_55,
    ST_ERASE_30
  } seq_step_e;

  typedef struct packed {
    kind_e                kind;
    logic [IN_ADDR_W-1:0] addr;
    logic [BYTE_W-1:0]    data;
  } bus_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic              busy;
  } reply_t;

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 cfg_we_i     = 1'b0;
  cfg_idx_e             cfg_idx_i    = CFG_ERASE_TICKS;
  logic [TICK_W-1:0]    cfg_wdata_i  = '0;
  logic                 push         = 1'b0;
  logic                 full;
  kind_e                kind_i       = KIND_READ;
  logic [IN_ADDR_W-1:0] address_i    = '0;
  logic [BYTE_W-1:0]    write_data_i = '0;
  logic                 empty;
  logic                 pop          = 1'b0;
  logic [BYTE_W-1:0]    read_data_o;
  logic                 busy_res_o;

  // Predicted chip state
  seq_step_e         step_q;
  logic              id_mode_q;
  logic              toggle_q;
  logic [TICK_W-1:0] busy_left;
  logic [BYTE_W-1:0] chip_mem [0:MEM_SIZE-1];
  logic [TICK_W-1:0] erase_ticks_q;
  logic [TICK_W-1:0] program_ticks_q;
  logic [BYTE_W-1:0] manuf_code_q;
  logic [BYTE_W-1:0] device_code_q;

  bus_word_t bus_words[$];
  reply_t    due_replies[$];

  int fail_count    = 0;
  int reply_no      = 0;
  int stuck_cycles  = 0;
  int queued        = 0;
  bit quiet_tail    = 1'b0;
  int drv_gap       = 0;
  int drv_mode_left = 0;
  bit drv_bursty    = 1'b0;
  int mon_stall     = 0;
  int mon_mode_left = 0;
  bit mon_bursty    = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  parallel_nor_flash_command_model_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .push         (push),
    .full         (full),
    .kind_i       (kind_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .empty        (empty),
    .pop          (pop),
    .read_data_o  (read_data_o),
    .busy_res_o   (busy_res_o)
  );

  // Advance the predicted chip by one bus word and return its reply.
  function automatic reply_t flash_respond(kind_e k, logic [IN_ADDR_W-1:0] a,
                                           logic [BYTE_W-1:0] d);
    reply_t                r;
    seq_step_e             nxt;
    logic [CMD_ADDR_W-1:0] ca;
    int                    base;
    int                    i;
    r.read_data = '0;
    ca = a[CMD_ADDR_W-1:0];
    nxt = ST_IDLE;
    case (k)
      KIND_READ: begin
        if (busy_left != 0) begin
          r.read_data = TOGGLE_BASE | (toggle_q ? TOGGLE_BIT : 8'h00);
          toggle_q = ~toggle_q;
        end else if (id_mode_q) begin
          r.read_data = a[0] ? device_code_q : manuf_code_q;
        end else begin
          r.read_data = chip_mem[a];
        end
      end
      KIND_WRITE: begin
        if (busy_left == 0) begin
          if (step_q == ST_PROGRAM) begin
            chip_mem[a] = chip_mem[a] & d;
            busy_left = program_ticks_q;
            step_q = ST_IDLE;
          end else if (d == CMD_F0) begin
            id_mode_q = 1'b0;
            step_q = ST_IDLE;
          end else begin
            case (step_q)
              ST_UNLOCK1: if (ca == UNLOCK2_ADDR && d == CMD_55) nxt = ST_UNLOCK2;
              ST_UNLOCK2: begin
                if (ca == UNLOCK1_ADDR) begin
                  if (d == CMD_90) id_mode_q = 1'b1;
                  else if (d == CMD_A0) nxt = ST_PROGRAM;
                  else if (d == CMD_80) nxt = ST_ERASE_AA;
                end
              end
              ST_ERASE_AA: if (ca == UNLOCK1_ADDR && d == CMD_AA) nxt = ST_ERASE_55;
              ST_ERASE_55: if (ca == UNLOCK2_ADDR && d == CMD_55) nxt = ST_ERASE_30;
              ST_ERASE_30: begin
                if (d == CMD_30) begin
                  base = int'(a) & ~(SEC_BYTES - 1);
                  for (i = 0; i < SEC_BYTES; i++) chip_mem[base + i] = ERASED_BYTE;
                  busy_left = erase_ticks_q;
                end
              end
              default: if (ca == UNLOCK1_ADDR && d == CMD_AA) nxt = ST_UNLOCK1;
            endcase
            step_q = nxt;
          end
        end
      end
      KIND_TICK: if (busy_left != 0) busy_left = busy_left - 1'b1;
      default: begin
      end
    endcase
    r.busy = (busy_left != 0);
    return r;
  endfunction

  function automatic logic [IN_ADDR_W-1:0] cmd_at(logic [CMD_ADDR_W-1:0] base);
    logic top;
    top = 1'($urandom_range(0, 1));
    return {top, base};
  endfunction

  // Mostly a small set of bytes spread over four sectors, so reads hit programmed data.
  function automatic logic [IN_ADDR_W-1:0] pick_addr();
    logic [IN_ADDR_W-1:0] a;
    a = IN_ADDR_W'($urandom);
    if ($urandom_range(0, 3) != 0) a = {a[15:14], 10'h000, a[3:0]};
    return a;
  endfunction

  function automatic int tick_run(logic [TICK_W-1:0] ticks);
    int n;
    n = (ticks > TICK_CLIP) ? TICK_CLIP : int'(ticks);
    if ($urandom_range(0, 4) == 0) n = $urandom_range(0, n);
    return n;
  endfunction

  task automatic add_word(kind_e k, logic [IN_ADDR_W-1:0] a, logic [BYTE_W-1:0] d);
    bus_word_t w;
    w.kind = k;
    w.addr = a;
    w.data = d;
    bus_words.push_back(w);
    queued++;
  endtask

  task automatic add_ticks(int n);
    repeat (n) add_word(KIND_TICK, IN_ADDR_W'($urandom), BYTE_W'($urandom));
  endtask

  // Wait until every word has been answered and any background erase is done.
  task automatic settle();
    while (bus_words.size() != 0 || push || due_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_store(cfg_idx_e idx, logic [TICK_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
  endtask

  task automatic set_config(logic [TICK_W-1:0] et, logic [TICK_W-1:0] pt,
                            logic [BYTE_W-1:0] mc, logic [BYTE_W-1:0] dc);
    cfg_store(CFG_ERASE_TICKS, et);
    cfg_store(CFG_PROGRAM_TICKS, pt);
    cfg_store(CFG_MANUF_CODE, {16'h0000, mc});
    cfg_store(CFG_DEVICE_CODE, {16'h0000, dc});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    erase_ticks_q   = et;
    program_ticks_q = pt;
    manuf_code_q    = mc;
    device_code_q   = dc;
  endtask

  task automatic gen_sequence();
    int                    pick;
    int                    n;
    int                    i;
    logic [IN_ADDR_W-1:0]  a;
    logic [BYTE_W-1:0]     d;
    logic [CMD_ADDR_W-1:0] ea [0:4];
    logic [BYTE_W-1:0]     ed [0:4];
    ea[0] = UNLOCK1_ADDR; ed[0] = CMD_AA;
    ea[1] = UNLOCK2_ADDR; ed[1] = CMD_55;
    ea[2] = UNLOCK1_ADDR; ed[2] = CMD_80;
    ea[3] = UNLOCK1_ADDR; ed[3] = CMD_AA;
    ea[4] = UNLOCK2_ADDR; ed[4] = CMD_55;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      add_word(KIND_WRITE, cmd_at(UNLOCK1_ADDR), CMD_AA);
      add_word(KIND_WRITE, cmd_at(UNLOCK2_ADDR), CMD_55);
      add_word(KIND_WRITE, cmd_at(UNLOCK1_ADDR), CMD_A0);
      a = pick_addr();
      d = ($urandom_range(0, 4) == 0) ? CMD_F0 : 8'($urandom);
      add_word(KIND_WRITE, a, d);
      repeat ($urandom_range(0, 2)) add_word(KIND_READ, a, BYTE_W'($urandom));
      add_ticks(tick_run(program_ticks_q));
      add_word(KIND_READ, a, BYTE_W'($urandom));
    end else if (pick < 33) begin
      for (i = 0; i < 5; i++) add_word(KIND_WRITE, cmd_at(ea[i]), ed[i]);
      a = pick_addr();
      add_word(KIND_WRITE, a, CMD_30);
      repeat ($urandom_range(0, 3)) add_word(KIND_READ, a, BYTE_W'($urandom));
      add_ticks(tick_run(erase_ticks_q));
      add_word(KIND_READ, a, BYTE_W'($urandom));
      add_word(KIND_READ, a ^ 16'h0001, BYTE_W'($urandom));
    end else if (pick < 48) begin
      add_word(KIND_WRITE, cmd_at(UNLOCK1_ADDR), CMD_AA);
      add_word(KIND_WRITE, cmd_at(UNLOCK2_ADDR), CMD_55);
      add_word(KIND_WRITE, cmd_at(UNLOCK1_ADDR), CMD_90);
      repeat ($urandom_range(1, 4))
        add_word(KIND_READ, IN_ADDR_W'($urandom), BYTE_W'($urandom));
      n = $urandom_range(0, 9);
      if (n < 5) begin
        add_word(KIND_WRITE, IN_ADDR_W'($urandom), CMD_F0);
      end else if (n < 9) begin
        add_word(KIND_WRITE, cmd_at(UNLOCK1_ADDR), CMD_AA);
        add_word(KIND_WRITE, cmd_at(UNLOCK2_ADDR), CMD_55);
        add_word(KIND_WRITE, cmd_at(UNLOCK1_ADDR), CMD_F0);
      end
    end else if (pick < 60) begin
      // Break an erase sequence part way, then finish it as if nothing happened.
      n = $urandom_range(1, 5);
      for (i = 0; i < n; i++) add_word(KIND_WRITE, cmd_at(ea[i]), ed[i]);
      if ($urandom_range(0, 1) == 0) begin
        add_word(KIND_WRITE, IN_ADDR_W'($urandom), BYTE_W'($urandom));
      end else begin
        a = cmd_at(ea[n % 5] ^ (15'd1 << $urandom_range(0, CMD_ADDR_W - 1)));
        add_word(KIND_WRITE, a, ed[n % 5]);
      end
      for (i = n; i < 5; i++) add_word(KIND_WRITE, cmd_at(ea[i]), ed[i]);
      a = pick_addr();
      add_word(KIND_WRITE, a, CMD_30);
      add_word(KIND_READ, a, BYTE_W'($urandom));
    end else if (pick < 75) begin
      repeat ($urandom_range(1, 6)) add_word(KIND_READ, pick_addr(), BYTE_W'($urandom));
    end else if (pick < 90) begin
      repeat ($urandom_range(1, 4))
        add_word(kind_e'($urandom_range(0, 3)), IN_ADDR_W'($urandom), BYTE_W'($urandom));
    end else begin
      add_ticks($urandom_range(1, 5));
    end
  endtask

  always @(posedge clk_i) begin : driver
    bus_word_t w;
    if (rst_ni && push && !full)
      due_replies.push_back(flash_respond(kind_i, address_i, write_data_i));
    if (drv_mode_left == 0) begin
      drv_bursty = ($urandom_range(0, 2) != 0);
      drv_mode_left = $urandom_range(30, 300);
    end else begin
      drv_mode_left--;
    end
    // Hold the word while the block is full.
    if (!push || !full) begin
      if (drv_gap == 0 && drv_bursty && !quiet_tail && $urandom_range(0, 5) == 0)
        drv_gap = $urandom_range(1, 10);
      if (drv_gap > 0 || bus_words.size() == 0) begin
        if (drv_gap > 0) drv_gap--;
        push <= 1'b0;
      end else begin
        w = bus_words.pop_front();
        push         <= 1'b1;
        kind_i       <= w.kind;
        address_i    <= w.addr;
        write_data_i <= w.data;
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    reply_t want;
    if ((push && !full) || (pop && !empty)) stuck_cycles = 0;
    else stuck_cycles++;
    if (rst_ni && pop && !empty) begin
      if (due_replies.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("reply %0d: none expected, got read_data %h busy %b",
                   reply_no, read_data_o, busy_res_o);
      end else begin
        want = due_replies.pop_front();
        if (want.read_data !== read_data_o || want.busy !== busy_res_o) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("reply %0d: expected read_data %h busy %b, got read_data %h busy %b",
                     reply_no, want.read_data, want.busy, read_data_o, busy_res_o);
        end
      end
      reply_no++;
    end
    if (mon_mode_left == 0) begin
      mon_bursty = ($urandom_range(0, 2) != 0);
      mon_mode_left = $urandom_range(30, 300);
    end else begin
      mon_mode_left--;
    end
    if (mon_stall == 0 && mon_bursty && !quiet_tail && $urandom_range(0, 5) == 0)
      mon_stall = $urandom_range(1, 10);
    if (mon_stall > 0) begin
      mon_stall--;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  initial begin : watchdog
    while (stuck_cycles < STUCK_LIMIT) @(posedge clk_i);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int i;
    for (i = 0; i < MEM_SIZE; i++) chip_mem[i] = ERASED_BYTE;
    step_q          = ST_IDLE;
    id_mode_q       = 1'b0;
    toggle_q        = 1'b0;
    busy_left       = '0;
    erase_ticks_q   = CFG_RESET.erase_ticks;
    program_ticks_q = CFG_RESET.program_ticks;
    manuf_code_q    = CFG_RESET.manuf_code;
    device_code_q   = CFG_RESET.device_code;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Power-up ID codes, unlock with address bit 15 set, exit by F0 anywhere
    add_word(KIND_WRITE, {1'b1, UNLOCK1_ADDR}, CMD_AA);
    add_word(KIND_WRITE, {1'b1, UNLOCK2_ADDR}, CMD_55);
    add_word(KIND_WRITE, {1'b0, UNLOCK1_ADDR}, CMD_90);
    add_word(KIND_READ, 16'h0000, 8'h00);
    add_word(KIND_READ, 16'hFFFF, 8'hFF);
    add_word(KIND_WRITE, 16'h1234, CMD_F0);
    add_word(KIND_READ, 16'h0001, 8'h00);
    settle();

    set_config(24'd2, 24'd1, 8'h00, 8'hFF);
    // Program, toggle read, write ignored while busy
    add_word(KIND_WRITE, cmd_at(UNLOCK1_ADDR), CMD_AA);
    add_word(KIND_WRITE, cmd_at(UNLOCK2_ADDR), CMD_55);
    add_word(KIND_WRITE, cmd_at(UNLOCK1_ADDR), CMD_A0);
    add_word(KIND_WRITE, 16'h8123, 8'h5A);
    add_word(KIND_READ, 16'h8123, 8'h00);
    add_word(KIND_WRITE, 16'h8123, 8'h00);
    add_word(KIND_TICK, 16'h0000, 8'h00);
    add_word(KIND_READ, 16'h8123, 8'h00);
    // Sector erase, both toggle values, then the erased byte
    add_word(KIND_WRITE, cmd_at(UNLOCK1_ADDR), CMD_AA);
    add_word(KIND_WRITE, cmd_at(UNLOCK2_ADDR), CMD_55);
    add_word(KIND_WRITE, cmd_at(UNLOCK1_ADDR), CMD_80);
    add_word(KIND_WRITE, cmd_at(UNLOCK1_ADDR), CMD_AA);
    add_word(KIND_WRITE, cmd_at(UNLOCK2_ADDR), CMD_55);
    add_word(KIND_WRITE, 16'h8155, CMD_30);
    add_word(KIND_READ, 16'h8123, 8'h00);
    add_word(KIND_READ, 16'h8123, 8'h00);
    add_word(KIND_TICK, 16'h0000, 8'h00);
    add_word(KIND_TICK, 16'h0000, 8'h00);
    add_word(KIND_READ, 16'h8123, 8'h00);
    add_word(KIND_NONE, 16'hFFFF, 8'hFF);
    settle();

    for (i = 0; i < 5; i++) begin
      case (i)
        0: set_config('0, '0, 8'($urandom), 8'($urandom));
        1: set_config(24'd1, 24'd1, 8'hFF, 8'h00);
        4: set_config(24'd5, 24'd3, 8'($urandom), 8'($urandom));
        default: set_config(24'($urandom_range(2, TICK_CLIP)), 24'($urandom_range(2, 6)),
                            8'($urandom), 8'($urandom));
      endcase
      queued = 0;
      while (queued < PHASE_WORDS) gen_sequence();
      settle();
    end

    // Longest busy windows: once programmed the chip stays busy to the end.
    set_config(TICKS_MAX, TICKS_MAX, 8'($urandom), 8'($urandom));
    quiet_tail = 1'b1;
    queued = 0;
    add_ticks(TICK_CLIP);
    add_word(KIND_WRITE, IN_ADDR_W'($urandom), CMD_F0);
    add_word(KIND_WRITE, cmd_at(UNLOCK1_ADDR), CMD_AA);
    add_word(KIND_WRITE, cmd_at(UNLOCK2_ADDR), CMD_55);
    add_word(KIND_WRITE, cmd_at(UNLOCK1_ADDR), CMD_A0);
    add_word(KIND_WRITE, pick_addr(), BYTE_W'($urandom));
    while (queued < TAIL_WORDS) begin
      case ($urandom_range(0, 4))
        0, 1: add_word(KIND_READ, pick_addr(), BYTE_W'($urandom));
        2: add_word(KIND_TICK, IN_ADDR_W'($urandom), BYTE_W'($urandom));
        3: add_word(KIND_WRITE, IN_ADDR_W'($urandom), BYTE_W'($urandom));
        default: add_word(KIND_NONE, IN_ADDR_W'($urandom), BYTE_W'($urandom));
      endcase
    end
    settle();

    if (fail_count == 0 && due_replies.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/pnfc_pkg.sv
sv/pnfc_ram.sv
sv/pnfc_queue.sv
sv/pnfc_front.sv
sv/pnfc_back.sv
sv/parallel_nor_flash_command_model_unit.sv
test/testbench.sv
